/* hdl/fome_pkg.sv */
// ----------------------------------------------------------------------------
// fome_pkg
// Shared types, constants and helpers of the fermion operator matrix element
// block: configuration record, result record, engine states, operator decode.
// ----------------------------------------------------------------------------
package fome_pkg;

	// Fixed field widths
	localparam int KET_W   = 32;
	localparam int ADDR_W  = 12;
	localparam int COL_W   = 12;
	localparam int SITE_W  = 5;
	localparam int LEN_W   = 3;
	localparam int KINDS_W = 4;
	localparam int SIZE_W  = 13;
	localparam int CFG_W   = 13;
	localparam int IDX_W   = 3;
	localparam int REG_SLOTS = 4;

	// Operator count and site range of the term
	localparam int MAX_OPERATORS = 4;
	localparam int SITE_COUNT    = 32;
	localparam int KW            = $clog2(MAX_OPERATORS + 1);

	// Default table depth
	localparam int BASIS_DEPTH_DEF = 4096;

	// Operator kind
	localparam logic CREATION = 1'b1;

	// Input item kind carried on tuser
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_KET  = 1'b1;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_TERM_LENGTH = 3'd0;
	localparam logic [IDX_W-1:0] REG_SITE_FIRST  = 3'd1;
	localparam logic [IDX_W-1:0] REG_SITE_SECOND = 3'd2;
	localparam logic [IDX_W-1:0] REG_SITE_THIRD  = 3'd3;
	localparam logic [IDX_W-1:0] REG_SITE_FOURTH = 3'd4;
	localparam logic [IDX_W-1:0] REG_KINDS       = 3'd5;
	localparam logic [IDX_W-1:0] REG_BASIS_SIZE  = 3'd6;

	typedef struct packed {
		logic [LEN_W-1:0]   term_length;
		logic [SITE_W-1:0]  site_first;
		logic [SITE_W-1:0]  site_second;
		logic [SITE_W-1:0]  site_third;
		logic [SITE_W-1:0]  site_fourth;
		logic [KINDS_W-1:0] kinds;
		logic [SIZE_W-1:0]  basis_size;
	} cfg_t;

	typedef struct packed {
		logic              nonzero;
		logic [ADDR_W-1:0] row;
		logic [COL_W-1:0]  column;
		logic              negative;
		logic              missing;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_SEED,
		ST_SEARCH,
		ST_DONE
	} eng_state_t;

	// Site of operator idx; operators past the register set sit on site 0
	function automatic logic [SITE_W-1:0] op_site(input cfg_t cfg, input logic [KW-1:0] idx);
		logic [SITE_W-1:0] s;
		s = '0;
		case (32'(idx))
			0: s = cfg.site_first;
			1: s = cfg.site_second;
			2: s = cfg.site_third;
			3: s = cfg.site_fourth;
			default: s = '0;
		endcase
		return s;
	endfunction

	// Kind of operator idx; operators past the register set annihilate
	function automatic logic op_kind(input cfg_t cfg, input logic [KW-1:0] idx);
		logic k;
		k = 1'b0;
		if (32'(idx) < REG_SLOTS) begin
			k = cfg.kinds[2'(idx)];
		end
		return k;
	endfunction

endpackage

/* hdl/fome_basis_mem.sv */
// ----------------------------------------------------------------------------
// fome_basis_mem
// Left basis table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fome_basis_mem #(
	parameter int BASIS_DEPTH = fome_pkg::BASIS_DEPTH_DEF,
	localparam int AW = $clog2(BASIS_DEPTH)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [fome_pkg::KET_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [fome_pkg::KET_W-1:0] rd_data
);

	logic [fome_pkg::KET_W-1:0] mem [BASIS_DEPTH];

	// Store a loaded entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Fetch one entry, data valid the next cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hdl/fome_engine.sv */
// ----------------------------------------------------------------------------
// fome_engine
// Sequencer for one ket: applies the operators one per cycle, then runs the
// binary search over the basis table, one probe per cycle.
// ----------------------------------------------------------------------------
module fome_engine #(
	parameter int BASIS_DEPTH = fome_pkg::BASIS_DEPTH_DEF,
	localparam int AW = $clog2(BASIS_DEPTH),
	localparam int SW = $clog2(BASIS_DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fome_pkg::KET_W-1:0]  ket,
	input  logic [fome_pkg::COL_W-1:0]  column,
	input  fome_pkg::cfg_t              cfg,
	output logic                        idle,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr,
	input  logic [fome_pkg::KET_W-1:0]  rd_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output fome_pkg::result_t           res
);

	localparam int KW = fome_pkg::KW;

	fome_pkg::eng_state_t state_q, state_d;

	logic [fome_pkg::KET_W-1:0]  v_q;
	logic [fome_pkg::COL_W-1:0]  col_q;
	logic                        sign_q;
	logic [KW-1:0]               k_q;
	logic                        nz_q;
	logic                        miss_q;
	logic [fome_pkg::ADDR_W-1:0] row_q;
	logic [SW-1:0]               lo_q;
	logic [SW-1:0]               hx_q;
	logic [AW-1:0]               mid_q;

	logic [KW-1:0]                len_sat;
	logic [SW-1:0]                size_sat;
	logic [KW-1:0]                op_idx;
	logic [fome_pkg::SITE_W-1:0]  site;
	logic                         kind;
	logic [fome_pkg::KET_W-1:0]   site_bit;
	logic                         occupied;
	logic                         op_ok;
	logic                         parity;
	logic                         hit;
	logic                         above;
	logic [SW-1:0]                lo_n;
	logic [SW-1:0]                hx_n;
	logic [AW-1:0]                seed_mid;
	logic [AW-1:0]                next_mid;

	// Midpoint of the half-open range [lo, hx)
	function automatic logic [AW-1:0] mid_of(input logic [SW-1:0] lo, input logic [SW-1:0] hx);
		logic [SW:0] s;
		s = {1'b0, lo} + {1'b0, hx} - (SW+1)'(1);
		return AW'(s >> 1);
	endfunction

	// Saturate term length and table size
	assign len_sat  = (32'(cfg.term_length) > fome_pkg::MAX_OPERATORS) ?
	                  KW'(fome_pkg::MAX_OPERATORS) : KW'(cfg.term_length);
	assign size_sat = (32'(cfg.basis_size) > BASIS_DEPTH) ?
	                  SW'(BASIS_DEPTH) : SW'(cfg.basis_size);

	// Decode and check the current operator
	assign op_idx   = k_q - KW'(1);
	assign site     = fome_pkg::op_site(cfg, op_idx);
	assign kind     = fome_pkg::op_kind(cfg, op_idx);
	assign site_bit = fome_pkg::KET_W'(1) << site;
	assign occupied = |(v_q & site_bit);
	assign op_ok    = (32'(site) < fome_pkg::SITE_COUNT) &&
	                  ((kind == fome_pkg::CREATION) ? !occupied : occupied);
	assign parity   = ^(v_q & (site_bit - fome_pkg::KET_W'(1)));

	// Compare the fetched entry and narrow the range
	assign hit      = (v_q == rd_data);
	assign above    = (v_q > rd_data);
	assign lo_n     = above ? (SW'(mid_q) + SW'(1)) : lo_q;
	assign hx_n     = above ? hx_q : SW'(mid_q);
	assign seed_mid = mid_of('0, size_sat);
	assign next_mid = mid_of(lo_n, hx_n);

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fome_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory requests
	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr   = seed_mid;
		res_valid = 1'b0;
		case (state_q)
			fome_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (len_sat == '0) ? fome_pkg::ST_SEED : fome_pkg::ST_APPLY;
				end
			end
			fome_pkg::ST_APPLY: begin
				if (!op_ok) begin
					state_d = fome_pkg::ST_DONE;
				end else if (k_q == KW'(1)) begin
					state_d = fome_pkg::ST_SEED;
				end
			end
			fome_pkg::ST_SEED: begin
				if (size_sat == '0) begin
					state_d = fome_pkg::ST_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = seed_mid;
					state_d = fome_pkg::ST_SEARCH;
				end
			end
			fome_pkg::ST_SEARCH: begin
				if (hit || (lo_n >= hx_n)) begin
					state_d = fome_pkg::ST_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = next_mid;
				end
			end
			fome_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = fome_pkg::ST_IDLE;
				end
			end
			default: state_d = fome_pkg::ST_IDLE;
		endcase
	end

	// Advance the ket, sign, bounds and result
	always_ff @(posedge clk) begin
		case (state_q)
			fome_pkg::ST_IDLE: begin
				if (start) begin
					v_q    <= ket;
					col_q  <= column;
					sign_q <= 1'b0;
					k_q    <= len_sat;
					nz_q   <= 1'b1;
					miss_q <= 1'b0;
					row_q  <= '0;
				end
			end
			fome_pkg::ST_APPLY: begin
				if (op_ok) begin
					v_q    <= v_q ^ site_bit;
					sign_q <= sign_q ^ parity;
					k_q    <= k_q - KW'(1);
				end else begin
					nz_q <= 1'b0;
				end
			end
			fome_pkg::ST_SEED: begin
				lo_q  <= '0;
				hx_q  <= size_sat;
				mid_q <= seed_mid;
				if (size_sat == '0) begin
					miss_q <= 1'b1;
				end
			end
			fome_pkg::ST_SEARCH: begin
				if (hit) begin
					row_q <= fome_pkg::ADDR_W'(32'(mid_q));
				end else begin
					lo_q  <= lo_n;
					hx_q  <= hx_n;
					mid_q <= next_mid;
					if (lo_n >= hx_n) begin
						miss_q <= 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign idle         = (state_q == fome_pkg::ST_IDLE);
	assign res.nonzero  = nz_q;
	assign res.row      = row_q;
	assign res.column   = col_q;
	assign res.negative = nz_q & sign_q;
	assign res.missing  = miss_q;

endmodule

/* hdl/fermion_operator_matrix_element.sv */
// Timing: a table load is written in the cycle it transfers and gives no result.
// A ket is taken in the idle state, then passes the apply steps (one per operator,
// up to term_length), the seed step and the search probes (at most
// ceil(log2(size + 1)), one per cycle through the registered table read) to its
// result register; a failed check ends early. No new ket or load is taken until the
// engine is idle again, which waits on a stalled output; one load per cycle while idle.
// Reset: registers return to term_length 1, all else 0; table contents stay undefined.
// ----------------------------------------------------------------------------
// fermion_operator_matrix_element
// Applies a product of fermionic operators to occupation kets and looks the
// resulting ket up in a sorted left basis table.
// ----------------------------------------------------------------------------
module fermion_operator_matrix_element #(
	parameter int BASIS_DEPTH = fome_pkg::BASIS_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration writes
	input  logic                         cfg_wr_en,
	input  logic [fome_pkg::IDX_W-1:0]   cfg_index,
	input  logic [fome_pkg::CFG_W-1:0]   cfg_data,
	// Input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [55:0]                  s_tdata,  // table_address[11:0], ket[43:12], column[55:44]
	input  logic                         s_tuser,  // action
	// Output stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata   // nonzero[0], row[12:1], column_out[24:13],
	                                               // negative[25], row_missing[26], zero[31:27]
);

	localparam int AW = $clog2(BASIS_DEPTH);

	fome_pkg::cfg_t    cfg_q;
	fome_pkg::result_t res;
	fome_pkg::result_t out_q;
	logic              out_valid_q;

	logic                        accept;
	logic                        eng_idle;
	logic                        start;
	logic [31:0]                 addr_wide;
	logic                        wr_en;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic [fome_pkg::KET_W-1:0]  rd_data;
	logic                        res_valid;
	logic                        res_ready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.term_length <= fome_pkg::LEN_W'(1);
			cfg_q.site_first  <= '0;
			cfg_q.site_second <= '0;
			cfg_q.site_third  <= '0;
			cfg_q.site_fourth <= '0;
			cfg_q.kinds       <= '0;
			cfg_q.basis_size  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				fome_pkg::REG_TERM_LENGTH: cfg_q.term_length <= cfg_data[fome_pkg::LEN_W-1:0];
				fome_pkg::REG_SITE_FIRST:  cfg_q.site_first  <= cfg_data[fome_pkg::SITE_W-1:0];
				fome_pkg::REG_SITE_SECOND: cfg_q.site_second <= cfg_data[fome_pkg::SITE_W-1:0];
				fome_pkg::REG_SITE_THIRD:  cfg_q.site_third  <= cfg_data[fome_pkg::SITE_W-1:0];
				fome_pkg::REG_SITE_FOURTH: cfg_q.site_fourth <= cfg_data[fome_pkg::SITE_W-1:0];
				fome_pkg::REG_KINDS:       cfg_q.kinds       <= cfg_data[fome_pkg::KINDS_W-1:0];
				fome_pkg::REG_BASIS_SIZE:  cfg_q.basis_size  <= cfg_data[fome_pkg::SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input transfer: loads go straight to the table, kets start the engine
	assign s_tready  = eng_idle;
	assign accept    = s_tvalid & s_tready;
	assign start     = accept & (s_tuser == fome_pkg::ACT_KET);
	assign addr_wide = 32'(s_tdata[11:0]);
	assign wr_en     = accept & (s_tuser == fome_pkg::ACT_LOAD) & (addr_wide < 32'(BASIS_DEPTH));

	fome_basis_mem #(
		.BASIS_DEPTH(BASIS_DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(addr_wide)),
		.wr_data (s_tdata[43:12]),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	fome_engine #(
		.BASIS_DEPTH(BASIS_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.ket       (s_tdata[43:12]),
		.column    (s_tdata[55:44]),
		.cfg       (cfg_q),
		.idle      (eng_idle),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: take a result whenever the slot is free or draining
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_q.missing, out_q.negative, out_q.column, out_q.row,
	                   out_q.nonzero};

endmodule
